// File: rtl/core/bmsu_pkg.sv
// Shared constants, types and sample-axis helper for the bilinear mask scaler.
`timescale 1ns / 1ps
`default_nettype none
package bmsu_pkg;

    localparam int SRC_MAX  = 256;
    localparam int DST_MAX  = 512;
    localparam int ADDR_W   = 16;
    localparam int PIX_W    = 8;
    localparam int SRC_W    = 9;
    localparam int DST_W    = 10;
    localparam int STEP_W   = 25;
    localparam int POS_W    = 9;
    localparam int PROD_W   = POS_W + STEP_W;
    localparam int IDX_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 1'd1;

    localparam logic [STEP_W-1:0] STEP_RESET  = 25'd65536;
    localparam logic [PROD_W-1:0] HALF_PIXEL  = PROD_W'(32768);
    localparam logic [SRC_W-1:0]  SRC_RESET   = 9'd256;
    localparam logic [DST_W-1:0]  DST_RESET   = 10'd256;

    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [7:0]       frac;
    } axis_t;

    typedef struct packed {
        logic             start;
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
    } div_req_t;

    function automatic axis_t sample_axis(input logic [PROD_W-1:0] p,
                                          input logic [SRC_W-1:0] src);
        logic [PROD_W-1:0] q;
        logic [PROD_W-17:0] whole;
        logic [IDX_W-1:0] last;
        axis_t r;
        q = (p < HALF_PIXEL) ? '0 : p - HALF_PIXEL;
        whole = q[PROD_W-1:16];
        last = IDX_W'(src - 9'd1);
        r.frac = q[15:8];
        r.lo = (whole > (PROD_W-16)'(last)) ? last : whole[IDX_W-1:0];
        r.hi = ((SRC_W'(r.lo) + 9'd1) < src) ? r.lo + 8'd1 : r.lo;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bmsu_mask_ram.sv
// One copy of the mask store: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bmsu_mask_ram (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic                       we,
    input  wire logic [bmsu_pkg::ADDR_W-1:0] waddr,
    input  wire logic [bmsu_pkg::PIX_W-1:0]  wdata,
    input  wire logic [bmsu_pkg::ADDR_W-1:0] raddr_a,
    input  wire logic [bmsu_pkg::ADDR_W-1:0] raddr_b,
    output logic      [bmsu_pkg::PIX_W-1:0]  rdata_a,
    output logic      [bmsu_pkg::PIX_W-1:0]  rdata_b
);
    import bmsu_pkg::*;

    logic [PIX_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/bmsu_step_div.sv
// Bit-serial restoring divider that derives the 9.16 sampling step.
`timescale 1ns / 1ps
`default_nettype none
module bmsu_step_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bmsu_pkg::div_req_t         req,
    output logic                            busy,
    output logic      [bmsu_pkg::STEP_W-1:0] step
);
    import bmsu_pkg::*;

    logic              busy_reg, busy_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [STEP_W-1:0] dvd_reg, dvd_next;
    logic [DST_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DST_W:0]    trial;
    logic              qbit;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[STEP_W-1]};
        qbit = (trial >= {1'b0, req.dst});
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'(STEP_W);
            dvd_next = {req.src, 16'd0};
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DST_W'(trial - {1'b0, req.dst}) : trial[DST_W-1:0];
            dvd_next = {dvd_reg[STEP_W-2:0], qbit};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                step_next = {dvd_reg[STEP_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            step_reg <= STEP_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign step = step_reg;
endmodule
`default_nettype wire

// File: rtl/core/bilinear_mask_scaler_unit.sv
// Top level of the bilinear alpha-mask scaler.
// A query result passes stages 1 to 5 and the output register; a stall holds it in place.
// Throughput: one item per cycle when not stalled; the duplicated store reads four taps at once.
// A configuration write holds input ready low through the write, the start and every divider step.
// Reset clears valid bits, sizes to 256 and the step to 1.0; the mask store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_mask_scaler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // load_index[15:0], load_value[23:16], out_col[32:24], out_row[41:33], zero fill
    input  wire logic [47:0] s_axis_tdata,
    // mode[0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // alpha[7:0], pixel_col[16:8], pixel_row[25:17], zero fill
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [bmsu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bmsu_pkg::CFG_W-1:0]     cfg_data
);
    import bmsu_pkg::*;

    logic [SRC_W-1:0]  src_reg;
    logic [DST_W-1:0]  dst_reg;
    logic              start_reg;
    logic              div_busy;
    logic [STEP_W-1:0] step;
    div_req_t          req;
    logic              adv, acc;

    logic [SRC_W-1:0] src_in;
    logic [DST_W-1:0] dst_in;

    always_comb
    begin
        src_in = cfg_data[SRC_W-1:0];
        if (src_in == '0)
            src_in = 9'd1;
        else if (src_in > SRC_W'(SRC_MAX))
            src_in = SRC_W'(SRC_MAX);
        dst_in = cfg_data[DST_W-1:0];
        if (dst_in == '0)
            dst_in = 10'd1;
        else if (dst_in > DST_W'(DST_MAX))
            dst_in = DST_W'(DST_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SRC_RESET;
            dst_reg <= DST_RESET;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SOURCE_SIZE: src_reg <= src_in;
                    CFG_OUTPUT_SIZE: dst_reg <= dst_in;
                    default: ;
                endcase
            end
        end
    end

    assign req.start = start_reg;
    assign req.src = src_reg;
    assign req.dst = dst_reg;

    bmsu_step_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .busy (div_busy),
        .step (step)
    );

    logic m_vld_reg;
    assign adv = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = adv && !div_busy && !start_reg && !cfg_we;
    assign acc = s_axis_tvalid && s_axis_tready;

    // Stage 1: position products.
    logic              v1_reg, q1_reg;
    logic [PROD_W-1:0] pc1_reg, pr1_reg;
    logic [POS_W-1:0]  col1_reg, row1_reg;
    logic [ADDR_W-1:0] li1_reg;
    logic [PIX_W-1:0]  lv1_reg;
    logic [POS_W-1:0]  in_col, in_row;
    logic [PROD_W-1:0] half_step;

    assign in_col = s_axis_tdata[32:24];
    assign in_row = s_axis_tdata[41:33];
    assign half_step = PROD_W'(step >> 1);

    // Stage 2: neighbor indexes and weights.
    logic             v2_reg, q2_reg;
    axis_t            ax2_reg, ay2_reg;
    logic [POS_W-1:0] col2_reg, row2_reg;
    logic [ADDR_W-1:0] li2_reg;
    logic [PIX_W-1:0] lv2_reg;

    // Stage 3: store addresses.
    logic              v3_reg, q3_reg;
    logic [ADDR_W-1:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic [7:0]        fx3_reg, fy3_reg;
    logic [POS_W-1:0]  col3_reg, row3_reg;
    logic [ADDR_W-1:0] li3_reg;
    logic [PIX_W-1:0]  lv3_reg;
    logic [SRC_W+IDX_W-1:0] base0, base1;

    assign base0 = (SRC_W+IDX_W)'(ay2_reg.lo) * (SRC_W+IDX_W)'(src_reg);
    assign base1 = (SRC_W+IDX_W)'(ay2_reg.hi) * (SRC_W+IDX_W)'(src_reg);

    // Stage 4: store data.
    logic             v4_reg, q4_reg;
    logic [7:0]       fx4_reg, fy4_reg;
    logic [POS_W-1:0] col4_reg, row4_reg;
    logic [PIX_W-1:0] pa, pb, pc, pe;
    logic             wr_en;

    assign wr_en = adv && v3_reg && !q3_reg;

    bmsu_mask_ram u_ram_top (
        .clk(clk), .en(adv), .we(wr_en), .waddr(li3_reg), .wdata(lv3_reg),
        .raddr_a(a00_reg), .raddr_b(a01_reg), .rdata_a(pa), .rdata_b(pb)
    );

    bmsu_mask_ram u_ram_bot (
        .clk(clk), .en(adv), .we(wr_en), .waddr(li3_reg), .wdata(lv3_reg),
        .raddr_a(a10_reg), .raddr_b(a11_reg), .rdata_a(pc), .rdata_b(pe)
    );

    // Stage 5: horizontal blend.
    logic             v5_reg, q5_reg;
    logic [15:0]      top5_reg, bot5_reg;
    logic [7:0]       fy5_reg;
    logic [POS_W-1:0] col5_reg, row5_reg;
    logic [8:0]       wx0, wx1, wy0, wy1;
    logic [16:0]      top_sum, bot_sum;
    logic [24:0]      out_sum;

    assign wx1 = {1'b0, fx4_reg};
    assign wx0 = 9'd256 - wx1;
    assign top_sum = 17'(pa) * 17'(wx0) + 17'(pb) * 17'(wx1);
    assign bot_sum = 17'(pc) * 17'(wx0) + 17'(pe) * 17'(wx1);
    assign wy1 = {1'b0, fy5_reg};
    assign wy0 = 9'd256 - wy1;
    assign out_sum = 25'(top5_reg) * 25'(wy0) + 25'(bot5_reg) * 25'(wy1);

    // Output register.
    logic [7:0]       alpha_reg;
    logic [POS_W-1:0] pcol_reg, prow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && q3_reg;
            v5_reg <= v4_reg;
            m_vld_reg <= v5_reg && q5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg <= s_axis_tuser[0];
            pc1_reg <= PROD_W'(in_col) * PROD_W'(step) + half_step;
            pr1_reg <= PROD_W'(in_row) * PROD_W'(step) + half_step;
            col1_reg <= in_col;
            row1_reg <= in_row;
            li1_reg <= s_axis_tdata[15:0];
            lv1_reg <= s_axis_tdata[23:16];

            q2_reg <= q1_reg;
            ax2_reg <= sample_axis(pc1_reg, src_reg);
            ay2_reg <= sample_axis(pr1_reg, src_reg);
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            li2_reg <= li1_reg;
            lv2_reg <= lv1_reg;

            q3_reg <= q2_reg;
            a00_reg <= ADDR_W'(base0 + (SRC_W+IDX_W)'(ax2_reg.lo));
            a01_reg <= ADDR_W'(base0 + (SRC_W+IDX_W)'(ax2_reg.hi));
            a10_reg <= ADDR_W'(base1 + (SRC_W+IDX_W)'(ax2_reg.lo));
            a11_reg <= ADDR_W'(base1 + (SRC_W+IDX_W)'(ax2_reg.hi));
            fx3_reg <= ax2_reg.frac;
            fy3_reg <= ay2_reg.frac;
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
            li3_reg <= li2_reg;
            lv3_reg <= lv2_reg;

            q4_reg <= q3_reg;
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;

            q5_reg <= q4_reg;
            top5_reg <= top_sum[15:0];
            bot5_reg <= bot_sum[15:0];
            fy5_reg <= fy4_reg;
            col5_reg <= col4_reg;
            row5_reg <= row4_reg;

            alpha_reg <= out_sum[23:16];
            pcol_reg <= col5_reg;
            prow_reg <= row5_reg;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata = {6'd0, prow_reg, pcol_reg, alpha_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        (div_busy || start_reg) |-> !acc)
        else $error("item accepted while the step is being computed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!div_busy && !start_reg && ({1'b0, src_reg} == dst_reg)) |-> (step == STEP_RESET))
        else $error("equal sizes must give a unit step");

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(v5_reg) && $stable(alpha_reg) && $stable(v4_reg)))
        else $error("pipeline moved during a stall");
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the bilinear alpha-mask scaler top level.
`timescale 1ns / 1ps
module tb;
    import bmsu_pkg::*;

    typedef struct {
        logic        mode;
        logic [15:0] load_index;
        logic [7:0]  load_value;
        logic [8:0]  out_col;
        logic [8:0]  out_row;
    } req_t;

    typedef struct {
        logic [7:0] alpha;
        logic [8:0] pixel_col;
        logic [8:0] pixel_row;
    } pixel_t;

    localparam int LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_SIZE;
    logic [CFG_W-1:0]     cfg_data = '0;

    req_t   pending_items[$];
    pixel_t expected_pixels[$];
    req_t   held_item;
    logic [7:0] mask_copy [0:65535];
    bit     loaded [0:65535];
    logic [8:0]  src_reg;
    logic [9:0]  dst_reg;
    logic [24:0] step_reg;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     no_idle = 0;
    int     cycles = 0;
    int     errors = 0;

    bilinear_mask_scaler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic int used_src();
        if (src_reg == 0) return 1;
        if (src_reg > SRC_MAX) return SRC_MAX;
        return src_reg;
    endfunction

    function automatic int used_dst();
        if (dst_reg == 0) return 1;
        if (dst_reg > DST_MAX) return DST_MAX;
        return dst_reg;
    endfunction

    function automatic void update_step();
        longint s;
        s = (longint'(used_src()) << 16) / used_dst();
        step_reg = (s > 64'h1FFFFFF) ? 25'h1FFFFFF : s[24:0];
    endfunction

    function automatic void axis_taps(input int pos, input int src,
                                      output int lo, output int hi, output int frac);
        longint p;
        longint whole;
        p = longint'(pos) * step_reg + (step_reg >> 1);
        p = (p < 32768) ? 0 : p - 32768;
        whole = p >> 16;
        frac = int'((p & 64'hFFFF) >> 8);
        lo = (whole > src - 1) ? src - 1 : int'(whole);
        hi = (lo + 1 < src) ? lo + 1 : lo;
    endfunction

    function automatic pixel_t blend_pixel(input req_t it);
        int src, x0, x1, y0, y1, fx, fy;
        int a, b, c, e, top, bot;
        pixel_t px;
        src = used_src();
        axis_taps(it.out_col, src, x0, x1, fx);
        axis_taps(it.out_row, src, y0, y1, fy);
        a = mask_copy[y0 * src + x0];
        b = mask_copy[y0 * src + x1];
        c = mask_copy[y1 * src + x0];
        e = mask_copy[y1 * src + x1];
        top = a * (256 - fx) + b * fx;
        bot = c * (256 - fx) + e * fx;
        px.alpha = 8'((top * (256 - fy) + bot * fy) >> 16);
        px.pixel_col = it.out_col;
        px.pixel_row = it.out_row;
        return px;
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_item.mode == 1'b0)
                    mask_copy[held_item.load_index] = held_item.load_value;
                else
                    expected_pixels.push_back(blend_pixel(held_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    held_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= held_item.mode;
                    s_axis_tdata <= {6'b0, held_item.out_row, held_item.out_col,
                                     held_item.load_value, held_item.load_index};
                    send_gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        pixel_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== want.alpha ||
                        m_axis_tdata[16:8] !== want.pixel_col ||
                        m_axis_tdata[25:17] !== want.pixel_row) begin
                        $display("%0t: expected alpha %0d col %0d row %0d, got alpha %0d col %0d row %0d",
                                 $time, want.alpha, want.pixel_col, want.pixel_row,
                                 m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tdata[25:17]);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("bilinear_mask_scaler_unit test failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SOURCE_SIZE) src_reg = 9'(value);
        else dst_reg = 10'(value);
        update_step();
        repeat (2) @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic push_load(input int idx, input int value);
        req_t it;
        it.mode = 1'b0;
        it.load_index = 16'(idx);
        it.load_value = 8'(value);
        it.out_col = 9'($urandom);
        it.out_row = 9'($urandom);
        pending_items.push_back(it);
    endtask

    // Loads a store entry ahead of the first query that reads it.
    task automatic ensure_loaded(input int addr);
        if (!loaded[addr]) begin
            loaded[addr] = 1;
            push_load(addr, ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom);
        end
    endtask

    task automatic push_query(input int col, input int row);
        req_t it;
        int src, x0, x1, y0, y1, fx, fy;
        src = used_src();
        axis_taps(col, src, x0, x1, fx);
        axis_taps(row, src, y0, y1, fy);
        ensure_loaded(y0 * src + x0);
        ensure_loaded(y0 * src + x1);
        ensure_loaded(y1 * src + x0);
        ensure_loaded(y1 * src + x1);
        it.mode = 1'b1;
        it.load_index = 16'($urandom);
        it.load_value = 8'($urandom);
        it.out_col = 9'(col);
        it.out_row = 9'(row);
        pending_items.push_back(it);
    endtask

    int src_list [12] = '{1, 0, 4, 8, 2, 5, 256, 300, 3, 511, 16, 7};
    int dst_list [12] = '{1, 0, 7, 3, 512, 1023, 256, 200, 511, 1, 16, 20};

    initial begin
        int d;
        src_reg = SRC_RESET;
        dst_reg = DST_RESET;
        step_reg = STEP_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            no_idle = ($urandom_range(3) == 0);
            write_reg(CFG_SOURCE_SIZE, src_list[ph]);
            write_reg(CFG_OUTPUT_SIZE, dst_list[ph]);
            d = used_dst();
            if (ph == 0) begin
                push_query(0, 0);
                push_query(511, 511);
                push_query(511, 0);
                push_query(0, 511);
            end else if (ph == 4) begin
                push_query(0, 0);
                push_query(511, 511);
                push_query(d - 1, 0);
                push_query(256, 255);
            end
            for (int k = 0; k < 45; k++) begin
                case ($urandom_range(9))
                    0: begin
                        d = $urandom_range(used_src() * used_src() - 1);
                        loaded[d] = 1;
                        push_load(d, $urandom);
                    end
                    1: push_query($urandom_range(511), $urandom_range(511));
                    default: push_query($urandom_range(used_dst() - 1),
                                        $urandom_range(used_dst() - 1));
                endcase
            end
        end
        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("bilinear_mask_scaler_unit test passed");
        else
            $display("bilinear_mask_scaler_unit test failed");
        $finish;
    end
endmodule

// File: bilinear_mask_scaler_unit.f
rtl/core/bmsu_pkg.sv
rtl/core/bmsu_mask_ram.sv
rtl/core/bmsu_step_div.sv
rtl/core/bilinear_mask_scaler_unit.sv
tb/tb.sv
